FILE: design/lsre_pkg.sv
// Shared types, constants and command codes of the link-state route engine.
package lsre_pkg;

  localparam int NODE_FIELD_W  = 5;
  localparam int COST_FIELD_W  = 12;
  localparam int PATH_COST_W   = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int DEF_MAX_NODES = 16;
  localparam int DEF_COST_BITS = 12;

  localparam logic [NODE_FIELD_W-1:0] NODE_COUNT_RST = 5'd16;
  localparam logic KIND_ROUTE = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [NODE_FIELD_W-1:0] node_a;
    logic [NODE_FIELD_W-1:0] node_b;
    logic [COST_FIELD_W-1:0] link_cost;
    logic                    link_down;
  } req_word_t;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] hop_node;
    logic [PATH_COST_W-1:0]  path_cost;
    logic [NODE_FIELD_W-1:0] first_hop;
    logic                    reachable;
    logic                    last;
  } rsp_word_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_WR_AB,
    OP_WR_BA,
    OP_OUT_NONE,
    OP_OUT_SELF,
    OP_INIT,
    OP_SCAN,
    OP_SETTLE,
    OP_RELAX,
    OP_PREP,
    OP_WALK_INIT,
    OP_PRED,
    OP_STEP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_route;
    logic link_ok;
    logic q_bad;
    logic q_same;
    logic cnt_last;
    logic best_none;
    logic rounds_done;
    logic b_reached;
    logic step_go;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/lsre_dp.sv
// Datapath: link memory, search scratch, hop list and result register.
module lsre_dp #(
  parameter int MAX_NODES = lsre_pkg::DEF_MAX_NODES,
  parameter int COST_BITS = lsre_pkg::DEF_COST_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lsre_pkg::dp_cmd_t                   cmd,
  output lsre_pkg::dp_status_t                status,
  input  lsre_pkg::req_word_t                 req_in,
  input  logic                                cfg_we,
  input  logic [lsre_pkg::NODE_FIELD_W-1:0]   cfg_data,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output lsre_pkg::rsp_word_t                 rsp
);
  import lsre_pkg::*;

  localparam int NODE_W  = $clog2(MAX_NODES + 1);
  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int DEPTH   = MAX_NODES * MAX_NODES;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIST_W  = COST_BITS + NODE_W;
  localparam int PATH_D  = MAX_NODES + 1;
  localparam int PATH_IW = $clog2(PATH_D);
  localparam int LEN_W   = $clog2(MAX_NODES + 2);
  localparam int K_W     = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic                 present;
    logic [COST_BITS-1:0] cost;
  } link_t;

  function automatic logic [IDX_W-1:0] nidx(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] m;
    m = node - 1'b1;
    return m[IDX_W-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [NODE_W-1:0] r,
                                            input logic [NODE_W-1:0] c);
    return AW'(nidx(r)) * AW'(MAX_NODES) + AW'(nidx(c));
  endfunction

  req_word_t               req;
  logic [NODE_FIELD_W-1:0] node_count;
  logic [NODE_W-1:0]       n_act;

  link_t                   mem [DEPTH];
  link_t                   rd_data;
  link_t                   wr_data;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           clr_addr;
  logic                    wr_en;

  logic [DIST_W-1:0]       node_dist [MAX_NODES];
  logic [MAX_NODES-1:0]    reached;
  logic [MAX_NODES-1:0]    settled;
  logic [NODE_W-1:0]       cnt;
  logic [NODE_W-1:0]       best;
  logic [NODE_W-1:0]       round;
  logic [NODE_W-1:0]       cur;
  logic [NODE_W-1:0]       pred;
  logic [NODE_W-1:0]       last_push;
  logic [NODE_W-1:0]       first;
  logic [DIST_W-1:0]       best_dist;
  logic [DIST_W-1:0]       cur_dist;
  logic [DIST_W-1:0]       dist_b;

  logic                    rd_vld;
  logic                    rd_pred;
  logic [NODE_W-1:0]       rd_node;

  logic [NODE_W-1:0]       path [PATH_D];
  logic [LEN_W-1:0]        len;
  logic [PATH_IW-1:0]      emit_idx;
  logic [K_W-1:0]          emit_k;
  logic [K_W-1:0]          emit_cnt;

  logic [NODE_W-1:0]       a_n;
  logic [NODE_W-1:0]       b_n;
  logic [IDX_W-1:0]        d_idx;
  logic [DIST_W-1:0]       dist_rd;
  logic [DIST_W-1:0]       relax_d;
  logic                    relax_upd;
  logic                    pred_hit;
  logic                    scan_upd;
  logic [PATH_COST_W-1:0]  cost_sat;
  logic                    rsp_load;

  assign a_n = NODE_W'(req.node_a);
  assign b_n = NODE_W'(req.node_b);

  // status toward the controller
  always_comb begin
    status.clr_done    = (clr_addr == AW'(DEPTH - 1));
    status.is_route    = (req.kind == KIND_ROUTE);
    status.link_ok     = (req.node_a != '0) && (req.node_b != '0) &&
                         (32'(req.node_a) <= MAX_NODES) && (32'(req.node_b) <= MAX_NODES);
    status.q_bad       = (req.node_a == '0) || (req.node_b == '0) ||
                         (32'(req.node_a) > 32'(n_act)) || (32'(req.node_b) > 32'(n_act));
    status.q_same      = (req.node_a == req.node_b);
    status.cnt_last    = (cnt == n_act);
    status.best_none   = (best == '0);
    status.rounds_done = (round == n_act);
    status.b_reached   = reached[nidx(b_n)];
    status.step_go     = (pred != '0) && (pred != a_n) && (32'(len) < 32'(n_act));
    status.emit_last   = (K_W'(emit_k + 1'b1) == emit_cnt);
    status.out_free    = !rsp_valid || !rsp_stall;
  end

  // single read index into the distance registers
  always_comb begin
    if (rd_vld) begin
      d_idx = nidx(rd_node);
    end else begin
      unique case (cmd.op)
        OP_STEP:      d_idx = nidx(pred);
        OP_WALK_INIT: d_idx = nidx(b_n);
        default:      d_idx = nidx(cnt);
      endcase
    end
  end

  assign dist_rd = node_dist[d_idx];

  // relax, predecessor and minimum-search decisions
  assign relax_d   = best_dist + DIST_W'(rd_data.cost);
  assign relax_upd = rd_vld && !rd_pred && (rd_node != best) && rd_data.present &&
                     (!reached[nidx(rd_node)] || (relax_d < dist_rd));
  assign pred_hit  = rd_vld && rd_pred && (pred == '0) && (rd_node != cur) &&
                     reached[nidx(rd_node)] && rd_data.present &&
                     ((dist_rd + DIST_W'(rd_data.cost)) == cur_dist);
  assign scan_upd  = reached[nidx(cnt)] && !settled[nidx(cnt)] &&
                     ((best == '0) || (dist_rd < best_dist));

  assign cost_sat = (|(dist_b >> PATH_COST_W)) ? '1 : PATH_COST_W'(dist_b);

  // a result word is loaded on any of the three output commands
  assign rsp_load = (cmd.op == OP_EMIT) || (cmd.op == OP_OUT_NONE) ||
                    (cmd.op == OP_OUT_SELF);

  // link memory addressing
  always_comb begin
    rd_addr = (cmd.op == OP_PRED) ? addr_of(cur, cnt) : addr_of(best, cnt);
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    unique case (cmd.op)
      OP_CLEAR: begin
        wr_en = 1'b1;
      end
      OP_WR_AB: begin
        wr_en           = 1'b1;
        wr_addr         = addr_of(a_n, b_n);
        wr_data.present = !req.link_down;
        wr_data.cost    = req.link_down ? '0 : COST_BITS'(req.link_cost);
      end
      OP_WR_BA: begin
        wr_en           = 1'b1;
        wr_addr         = addr_of(b_n, a_n);
        wr_data.present = !req.link_down;
        wr_data.cost    = req.link_down ? '0 : COST_BITS'(req.link_cost);
      end
      default: ;
    endcase
  end

  // link memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // search, walk and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      node_count <= NODE_COUNT_RST;
      rsp_valid  <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end

      rd_vld  <= (cmd.op == OP_RELAX) || (cmd.op == OP_PRED);
      rd_pred <= (cmd.op == OP_PRED);
      rd_node <= cnt;

      if (relax_upd) begin
        node_dist[nidx(rd_node)] <= relax_d;
        reached[nidx(rd_node)]   <= 1'b1;
      end
      if (pred_hit) begin
        pred <= rd_node;
      end

      // raise valid on a new word, drop it once taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (cmd.op)
        OP_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        OP_LOAD: begin
          req   <= req_in;
          n_act <= (32'(node_count) > MAX_NODES) ? NODE_W'(MAX_NODES) : NODE_W'(node_count);
        end
        OP_OUT_NONE: begin
          rsp <= '{hop_node: '0, path_cost: '0, first_hop: '0,
                   reachable: 1'b0, last: 1'b1};
        end
        OP_OUT_SELF: begin
          rsp <= '{hop_node: req.node_a, path_cost: '0, first_hop: req.node_a,
                   reachable: 1'b1, last: 1'b1};
        end
        OP_INIT: begin
          reached               <= MAX_NODES'(1) << nidx(a_n);
          settled               <= '0;
          node_dist[nidx(a_n)]  <= '0;
          round                 <= '0;
          cnt                   <= NODE_W'(1);
          best                  <= '0;
        end
        OP_SCAN: begin
          if (scan_upd) begin
            best      <= cnt;
            best_dist <= dist_rd;
          end
          cnt <= cnt + 1'b1;
        end
        OP_SETTLE: begin
          settled[nidx(best)] <= 1'b1;
          round               <= round + 1'b1;
          cnt                 <= NODE_W'(1);
        end
        OP_RELAX: begin
          cnt <= cnt + 1'b1;
        end
        OP_PREP: begin
          cnt  <= NODE_W'(1);
          best <= '0;
        end
        OP_WALK_INIT: begin
          cur      <= b_n;
          cur_dist <= dist_rd;
          dist_b   <= dist_rd;
          len      <= '0;
          pred     <= '0;
          cnt      <= NODE_W'(1);
        end
        OP_PRED: begin
          cnt <= cnt + 1'b1;
        end
        OP_STEP: begin
          path[len[PATH_IW-1:0]] <= status.step_go ? pred : a_n;
          len                    <= len + 1'b1;
          if (status.step_go) begin
            cur       <= pred;
            cur_dist  <= dist_rd;
            last_push <= pred;
            pred      <= '0;
            cnt       <= NODE_W'(1);
          end else begin
            first    <= (len != '0) ? last_push : b_n;
            emit_idx <= PATH_IW'(len);
            emit_k   <= '0;
            emit_cnt <= (32'(len) + 1 > MAX_RESULTS) ? K_W'(MAX_RESULTS)
                                                     : K_W'(len + 1'b1);
          end
        end
        OP_EMIT: begin
          rsp       <= '{hop_node: NODE_FIELD_W'(path[emit_idx]), path_cost: cost_sat,
                         first_hop: NODE_FIELD_W'(first), reachable: 1'b1,
                         last: status.emit_last};
          emit_idx  <= emit_idx - 1'b1;
          emit_k    <= emit_k + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/lsre_ctrl.sv
// Controller: sequences clearing, link writes, the search, the walk and the hop list.
module lsre_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  lsre_pkg::dp_status_t status,
  output lsre_pkg::dp_cmd_t    cmd
);
  import lsre_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_WR_AB,
    S_WR_BA,
    S_NONE,
    S_SELF,
    S_INIT,
    S_SCAN,
    S_PICK,
    S_RELAX,
    S_RELAX_END,
    S_WALK_CHK,
    S_PRED,
    S_PRED_END,
    S_STEP,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (!status.is_route) state_next = status.link_ok ? S_WR_AB : S_IDLE;
        else if (status.q_bad)         state_next = S_NONE;
        else if (status.q_same)        state_next = S_SELF;
        else                           state_next = S_INIT;
      end
      S_WR_AB: begin
        cmd.op     = OP_WR_AB;
        state_next = S_WR_BA;
      end
      S_WR_BA: begin
        cmd.op     = OP_WR_BA;
        state_next = S_IDLE;
      end
      S_NONE: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT_NONE;
          state_next = S_IDLE;
        end
      end
      S_SELF: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT_SELF;
          state_next = S_IDLE;
        end
      end
      S_INIT: begin
        cmd.op     = OP_INIT;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (status.cnt_last) state_next = S_PICK;
      end
      S_PICK: begin
        if (status.best_none) begin
          state_next = S_WALK_CHK;
        end else begin
          cmd.op     = OP_SETTLE;
          state_next = S_RELAX;
        end
      end
      S_RELAX: begin
        cmd.op = OP_RELAX;
        if (status.cnt_last) state_next = S_RELAX_END;
      end
      S_RELAX_END: begin
        cmd.op     = OP_PREP;
        state_next = status.rounds_done ? S_WALK_CHK : S_SCAN;
      end
      S_WALK_CHK: begin
        if (!status.b_reached) begin
          state_next = S_NONE;
        end else begin
          cmd.op     = OP_WALK_INIT;
          state_next = S_PRED;
        end
      end
      S_PRED: begin
        cmd.op = OP_PRED;
        if (status.cnt_last) state_next = S_PRED_END;
      end
      S_PRED_END: begin
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.op     = OP_STEP;
        state_next = status.step_go ? S_PRED : S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op = OP_EMIT;
          if (status.emit_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/link_state_route_engine_top.sv
// Top level of the link-state route engine: controller, datapath and ports.
//
//  channel | direction | handshake          | word
//  req     | in        | req_valid/req_stall | req_word_t (set-link or route query)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_word_t (one hop per word)
//  cfg     | in        | cfg_valid/cfg_ready | node_count
//
// After reset the link memory is swept clear, one entry a cycle, with req_stall high. A
// set-link word writes the link both ways, a to b and then b to a. A query over n nodes
// runs a search of at most n rounds (array minimum scan and a relax pass over one memory
// row per round, one read port), then a walk back that scans one memory row per node of
// the hop list, then one result word a cycle while rsp_stall is low. One query is worked
// at a time; a new word is taken while the last result word still waits on rsp_stall.
module link_state_route_engine_top #(
  parameter int MAX_NODES = lsre_pkg::DEF_MAX_NODES,
  parameter int COST_BITS = lsre_pkg::DEF_COST_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  lsre_pkg::req_word_t               req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output lsre_pkg::rsp_word_t               rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsre_pkg::NODE_FIELD_W-1:0] cfg_data
);
  import lsre_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  lsre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lsre_dp #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_in    (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // an accepted word closes the input until it is worked off
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input taken twice in a row");

  // an unreachable answer is a single last word with zero hop node, first hop and cost
  a_unreach_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.reachable |->
      rsp.last && (rsp.hop_node == '0) && (rsp.first_hop == '0) && (rsp.path_cost == '0))
    else $error("malformed unreachable result");

  // results only leave while a query is being answered
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.op == OP_EMIT || cmd.op == OP_OUT_NONE ||
                                cmd.op == OP_OUT_SELF))
    else $error("result word without a result command");
`endif

endmodule
